@@ hw/rtl/tfs_pkg.sv @@
// Package: widths, ASCII codes, digit types and frame byte selection for the telemetry serializer.
`default_nettype none

package tfs_pkg;

	localparam int DigitW  = 4;
	localparam int ValueW  = 10;
	localparam int ByteW   = 8;
	localparam int FrameLen = 21;
	localparam int IdxW    = $clog2(FrameLen);

	localparam logic [IdxW-1:0] IdxLast = IdxW'(FrameLen - 1);

	localparam logic [DigitW-1:0] DigitMax = 4'd9;
	localparam logic [ValueW-1:0] ValueMax = 10'd999;

	localparam logic [ByteW-1:0] ChDollar = 8'd36;
	localparam logic [ByteW-1:0] ChComma  = 8'd44;
	localparam logic [ByteW-1:0] ChPoint  = 8'd46;
	localparam logic [ByteW-1:0] ChZero   = 8'd48;
	localparam logic [ByteW-1:0] ChCr     = 8'd13;

	// Byte positions inside "$A,D,M,PPP,VV.V,TT.T<CR>"
	typedef enum logic [IdxW-1:0] {
		POS_DOLLAR = 5'd0,
		POS_CUR    = 5'd1,
		POS_COMMA0 = 5'd2,
		POS_TGT    = 5'd3,
		POS_COMMA1 = 5'd4,
		POS_MOTOR  = 5'd5,
		POS_COMMA2 = 5'd6,
		POS_POS_H  = 5'd7,
		POS_POS_T  = 5'd8,
		POS_POS_U  = 5'd9,
		POS_COMMA3 = 5'd10,
		POS_SPD_H  = 5'd11,
		POS_SPD_T  = 5'd12,
		POS_SPD_P  = 5'd13,
		POS_SPD_U  = 5'd14,
		POS_COMMA4 = 5'd15,
		POS_TMP_H  = 5'd16,
		POS_TMP_T  = 5'd17,
		POS_TMP_P  = 5'd18,
		POS_TMP_U  = 5'd19,
		POS_CR     = 5'd20
	} frame_pos_t;

	typedef struct packed {
		logic [DigitW-1:0] hund;
		logic [DigitW-1:0] tens;
		logic [DigitW-1:0] units;
	} three_digit_t;

	typedef struct packed {
		logic [DigitW-1:0] cur;
		logic [DigitW-1:0] tgt;
		logic [DigitW-1:0] motor;
		three_digit_t      pos;
		three_digit_t      spd;
		three_digit_t      tmp;
	} frame_digits_t;

	function automatic logic [ByteW-1:0] to_ascii(input logic [DigitW-1:0] d);
		return ChZero + {{(ByteW-DigitW){1'b0}}, d};
	endfunction

	function automatic logic [DigitW-1:0] sat_digit(input logic [DigitW-1:0] d);
		return (d > DigitMax) ? DigitMax : d;
	endfunction

	function automatic logic [ByteW-1:0] frame_byte_at(input frame_digits_t f,
		input logic [IdxW-1:0] idx);
		logic [ByteW-1:0] b;
		b = ChCr;
		unique case (frame_pos_t'(idx))
			POS_DOLLAR: b = ChDollar;
			POS_CUR:    b = to_ascii(f.cur);
			POS_TGT:    b = to_ascii(f.tgt);
			POS_MOTOR:  b = to_ascii(f.motor);
			POS_POS_H:  b = to_ascii(f.pos.hund);
			POS_POS_T:  b = to_ascii(f.pos.tens);
			POS_POS_U:  b = to_ascii(f.pos.units);
			POS_SPD_H:  b = to_ascii(f.spd.hund);
			POS_SPD_T:  b = to_ascii(f.spd.tens);
			POS_SPD_U:  b = to_ascii(f.spd.units);
			POS_TMP_H:  b = to_ascii(f.tmp.hund);
			POS_TMP_T:  b = to_ascii(f.tmp.tens);
			POS_TMP_U:  b = to_ascii(f.tmp.units);
			POS_SPD_P, POS_TMP_P: b = ChPoint;
			POS_COMMA0, POS_COMMA1, POS_COMMA2, POS_COMMA3, POS_COMMA4: b = ChComma;
			POS_CR:     b = ChCr;
			default:    b = ChCr;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tfs_if.sv @@
// Interfaces: snapshot input channel and frame byte output channel.
`default_nettype none

interface tfs_snap_if;
	logic                            valid;
	logic                            ready;
	logic [tfs_pkg::DigitW-1:0]      current_floor;
	logic [tfs_pkg::DigitW-1:0]      target_floor;
	logic [tfs_pkg::DigitW-1:0]      motor_state;
	logic [tfs_pkg::ValueW-1:0]      position_mm;
	logic [tfs_pkg::ValueW-1:0]      speed_tenths;
	logic [tfs_pkg::ValueW-1:0]      temperature_tenths;

	modport source (output valid, current_floor, target_floor, motor_state,
		position_mm, speed_tenths, temperature_tenths, input ready);
	modport sink (input valid, current_floor, target_floor, motor_state,
		position_mm, speed_tenths, temperature_tenths, output ready);
endinterface

interface tfs_byte_if;
	logic                       valid;
	logic                       ready;
	logic [tfs_pkg::ByteW-1:0]  frame_byte;
	logic                       frame_last;

	modport source (output valid, frame_byte, frame_last, input ready);
	modport sink (input valid, frame_byte, frame_last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tfs_digit_split.sv @@
// Saturate a 10-bit value to 999 and split it into hundreds, tens and units.
`default_nettype none

module tfs_digit_split (
	input  wire logic [tfs_pkg::ValueW-1:0] value,
	output tfs_pkg::three_digit_t           digits
);
	import tfs_pkg::*;

	logic [ValueW-1:0] sat;
	logic [15:0]       hund_prod;
	logic [DigitW-1:0] hund;
	logic [6:0]        rem;
	logic [14:0]       tens_prod;
	logic [DigitW-1:0] tens;

	// Divide by 100 as *41 >> 12 and by 10 as *205 >> 11; exact in these ranges.
	always_comb begin
		sat       = (value > ValueMax) ? ValueMax : value;
		hund_prod = {6'd0, sat} * 16'd41;
		hund      = hund_prod[15:12];
		rem       = 7'(sat - (ValueW'(hund) * 10'd100));
		tens_prod = {8'd0, rem} * 15'd205;
		tens      = tens_prod[14:11];
		digits.hund  = hund;
		digits.tens  = tens;
		digits.units = DigitW'(rem - (7'(tens) * 7'd10));
	end

endmodule

`default_nettype wire

@@ hw/rtl/telemetry_frame_serializer_core.sv @@
// Top level: telemetry snapshot to 21-byte ASCII frame serializer.
`default_nettype none

// Each accepted snapshot becomes the frame "$A,D,M,PPP,VV.V,TT.T" plus a carriage
// return, sent one byte per output transaction with frame_last set on the carriage
// return. The output port carries one byte per cycle while frame.ready is not held
// low, and back-to-back snapshots stream with no gap between frames. One snapshot
// is held in a buffer stage (already converted to digits) while the previous frame
// streams; from there a frame's bytes pass through the serializer stage and the output
// byte register. Out-of-range digits saturate to 9 and three-digit values to 999.
module telemetry_frame_serializer_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tfs_snap_if.sink    snap,
	tfs_byte_if.source  frame
);
	import tfs_pkg::*;

	three_digit_t      pos_d;
	three_digit_t      spd_d;
	three_digit_t      tmp_d;
	frame_digits_t     conv;
	frame_digits_t     dig_s1;
	logic              vld_s1;
	frame_digits_t     dig_s2;
	logic              busy_q;
	logic [IdxW-1:0]   idx_q;
	logic              out_vld_q;
	logic [ByteW-1:0]  out_byte_q;
	logic              out_last_q;

	logic out_free;
	logic emit;
	logic frame_done;
	logic load_s2;
	logic take;

	tfs_digit_split u_pos (.value(snap.position_mm),        .digits(pos_d));
	tfs_digit_split u_spd (.value(snap.speed_tenths),       .digits(spd_d));
	tfs_digit_split u_tmp (.value(snap.temperature_tenths), .digits(tmp_d));

	always_comb begin
		conv.cur   = sat_digit(snap.current_floor);
		conv.tgt   = sat_digit(snap.target_floor);
		conv.motor = sat_digit(snap.motor_state);
		conv.pos   = pos_d;
		conv.spd   = spd_d;
		conv.tmp   = tmp_d;
	end

	always_comb begin
		out_free   = !out_vld_q || frame.ready;
		emit       = busy_q && out_free;
		frame_done = emit && (idx_q == IdxLast);
		load_s2    = vld_s1 && (!busy_q || frame_done);
		take       = snap.valid && snap.ready;
		snap.ready = !vld_s1 || load_s2;
	end

	// Buffer stage: hold converted snapshot until the serializer picks it up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (load_s2) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			dig_s1 <= conv;
		end
	end

	// Serializer: advance one byte per output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load_s2) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (frame_done) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (emit) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			dig_s2 <= dig_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= frame_byte_at(dig_s2, idx_q);
			out_last_q <= (idx_q == IdxLast);
		end
	end

	always_comb begin
		frame.valid      = out_vld_q;
		frame.frame_byte = out_byte_q;
		frame.frame_last = out_last_q;
	end

`ifndef NO_ASSERTIONS
	a_last_is_cr: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && frame.frame_last |-> frame.frame_byte == ChCr)
		else $error("frame_last set on a byte other than carriage return");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= IdxLast)
		else $error("serializer index beyond frame length");

	a_first_dollar: assert property (@(posedge clk) disable iff (!arst_n)
		emit && idx_q == '0 |=> frame.valid && frame.frame_byte == ChDollar)
		else $error("frame does not start with dollar sign");

	a_take_buffers: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> vld_s1 || busy_q)
		else $error("accepted snapshot lost");
`endif

endmodule

`default_nettype wire
